[rtl/nfw_pkg.sv]
`default_nettype none

package nfw_pkg;

	localparam int CMD_W       = 3;
	localparam int ADDR_W      = 16;
	localparam int DATA_W      = 8;
	localparam int WEAR_W      = 20;
	localparam int STORE_BYTES = 65536;

	localparam int DEF_BLOCK_COUNT = 16;
	localparam int DEF_BLOCK_BYTES = 4096;

	localparam logic [DATA_W-1:0] ERASED_BYTE = 8'hFF;
	localparam logic [WEAR_W-1:0] WEAR_MAX    = 20'hFFFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_READ        = 3'd0,
		CMD_PROGRAM     = 3'd1,
		CMD_BLOCK_ERASE = 3'd2,
		CMD_CHIP_ERASE  = 3'd3,
		CMD_READ_WEAR   = 3'd4
	} cmd_t;

	typedef enum logic [3:0] {
		S_INIT,
		S_IDLE,
		S_DECODE,
		S_DISPATCH,
		S_RD_WAIT,
		S_PROG_WAIT,
		S_WALK,
		S_CNT_RD,
		S_CNT_WR,
		S_WEAR_RD,
		S_WEAR_GET,
		S_RESP
	} state_t;

endpackage

`default_nettype wire

[rtl/nfw_ram.sv]
`default_nettype none

module nfw_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/nor_flash_array_with_wear_count.sv]
`default_nettype none

// channel   | ports                                   | handshake
// ----------+-----------------------------------------+---------------------------------
// command   | cmd, address, write_data                | taken when start && !busy
// result    | read_data, wear_count                   | done high for one cycle, no stall
//
// states per item, after the accepting edge: S_DECODE, S_DISPATCH, then
//   read, program: S_RD_WAIT or S_PROG_WAIT (one flash access each), then S_RESP
//   read wear: S_WEAR_RD (the counter index is registered before its read), S_WEAR_GET, S_RESP
//   address outside the array, unused cmd: S_RESP
//   block erase: S_WALK (one byte write per cycle), then a counter update, then S_RESP
//   chip erase: S_WALK over min(BLOCK_COUNT*BLOCK_BYTES, 65536) bytes, a counter update per block, S_RESP
// after reset the first min(BLOCK_COUNT*BLOCK_BYTES, 65536) bytes of the array are swept
// to 0xFF, one byte per cycle, while busy stays high
// the block address comes from one shared reciprocal multiply; the receiver cannot
// stall, so a result is shown once and the block goes idle the cycle after

module nor_flash_array_with_wear_count
	import nfw_pkg::*;
#(
	parameter int BLOCK_COUNT = DEF_BLOCK_COUNT,
	parameter int BLOCK_BYTES = DEF_BLOCK_BYTES
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              start,
	output logic                   busy,
	input  wire logic [CMD_W-1:0]  cmd,
	input  wire logic [ADDR_W-1:0] address,
	input  wire logic [DATA_W-1:0] write_data,
	output logic                   done,
	output logic      [DATA_W-1:0] read_data,
	output logic      [WEAR_W-1:0] wear_count
);

	// block = address / BLOCK_BYTES by multiply with a rounded-up reciprocal;
	// exact for every 16-bit address
	localparam int DIV_L   = $clog2(BLOCK_BYTES);
	localparam int DIV_S   = ADDR_W + DIV_L;
	localparam int RECIP_W = ADDR_W + 2;
	localparam longint unsigned RECIP_VAL =
		((64'd1 << DIV_S) + 64'(BLOCK_BYTES) - 64'd1) / 64'(BLOCK_BYTES);
	localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
	localparam int PROD_W = ADDR_W + RECIP_W;
	localparam int QW     = ADDR_W - DIV_L + 1;
	localparam int BB_W   = $clog2(BLOCK_BYTES + 1);
	localparam int SF_W   = QW + BB_W;

	localparam int CNT_AW      = (BLOCK_COUNT > 1) ? $clog2(BLOCK_COUNT) : 1;
	localparam int ARRAY_BYTES = BLOCK_COUNT * BLOCK_BYTES;
	localparam int CHIP_END_I  = (ARRAY_BYTES < STORE_BYTES) ? ARRAY_BYTES : STORE_BYTES;
	localparam logic [ADDR_W:0] CHIP_END = (ADDR_W + 1)'(CHIP_END_I);
	localparam logic [CNT_AW-1:0] LAST_BLK = CNT_AW'(BLOCK_COUNT - 1);

	state_t state_q, state_d;

	// latched command
	logic [CMD_W-1:0]  cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [DATA_W-1:0] wdata_q;

	// shared multiplier output
	logic [PROD_W-1:0] prod_q;

	// erase walk and counter index
	logic [ADDR_W:0]   walk_q;
	logic [ADDR_W:0]   walk_end_q;
	logic [CNT_AW-1:0] cidx_q;
	logic              chip_q;
	logic [BLOCK_COUNT-1:0] cvalid_q;

	// result registers
	logic [DATA_W-1:0] rdata_q;
	logic [WEAR_W-1:0] wear_q;

	// decode results
	logic [QW-1:0]   blk_s;
	logic [SF_W-1:0] start_full;
	logic [SF_W:0]   end_sum;
	logic [ADDR_W:0] end_capped;
	logic            in_array;
	logic            walk_last;

	// memory ports
	logic              fwe;
	logic [ADDR_W-1:0] fwaddr;
	logic [DATA_W-1:0] fwdata;
	logic [DATA_W-1:0] frdata;
	logic              cwe;
	logic [WEAR_W-1:0] cwdata;
	logic [WEAR_W-1:0] crdata;
	logic [WEAR_W-1:0] cur_count;

	assign blk_s      = prod_q[DIV_S +: QW];
	assign start_full = SF_W'(blk_s) * SF_W'(BLOCK_BYTES);
	assign end_sum    = (SF_W + 1)'(start_full) + (SF_W + 1)'(BLOCK_BYTES);
	assign end_capped = (32'(end_sum) > STORE_BYTES) ? (ADDR_W + 1)'(STORE_BYTES)
	                                                 : (ADDR_W + 1)'(end_sum);
	assign in_array   = 32'(addr_q) < ARRAY_BYTES;
	assign walk_last  = (walk_q + (ADDR_W + 1)'(1)) == walk_end_q;

	// unwritten counters read as zero
	assign cur_count = cvalid_q[cidx_q] ? crdata : '0;
	assign cwdata    = (cur_count == WEAR_MAX) ? cur_count : cur_count + WEAR_W'(1);

	// flash array: 64k bytes
	nfw_ram #(
		.WIDTH (DATA_W),
		.DEPTH (STORE_BYTES)
	) u_flash (
		.clk   (clk),
		.we    (fwe),
		.waddr (fwaddr),
		.wdata (fwdata),
		.raddr (addr_q),
		.rdata (frdata)
	);

	// erase counters, one per block
	nfw_ram #(
		.WIDTH (WEAR_W),
		.DEPTH (BLOCK_COUNT)
	) u_counts (
		.clk   (clk),
		.we    (cwe),
		.waddr (cidx_q),
		.wdata (cwdata),
		.raddr (cidx_q),
		.rdata (crdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_INIT;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and memory controls
	always_comb begin
		state_d = state_q;
		fwe     = 1'b0;
		fwaddr  = addr_q;
		fwdata  = ERASED_BYTE;
		cwe     = 1'b0;
		case (state_q)
			S_INIT: begin
				fwe    = 1'b1;
				fwaddr = walk_q[ADDR_W-1:0];
				if (walk_q == CHIP_END - (ADDR_W + 1)'(1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start) begin
					state_d = S_DECODE;
				end
			end
			S_DECODE: begin
				state_d = S_DISPATCH;
			end
			S_DISPATCH: begin
				case (cmd_t'(cmd_q))
					CMD_READ:        state_d = in_array ? S_RD_WAIT : S_RESP;
					CMD_PROGRAM:     state_d = in_array ? S_PROG_WAIT : S_RESP;
					CMD_BLOCK_ERASE: state_d = in_array ? S_WALK : S_RESP;
					CMD_CHIP_ERASE:  state_d = S_WALK;
					CMD_READ_WEAR:   state_d = in_array ? S_WEAR_RD : S_RESP;
					default:         state_d = S_RESP;
				endcase
			end
			S_RD_WAIT: begin
				state_d = S_RESP;
			end
			S_PROG_WAIT: begin
				// bits only fall from one to zero
				fwe     = 1'b1;
				fwdata  = frdata & wdata_q;
				state_d = S_RESP;
			end
			S_WALK: begin
				fwe    = 1'b1;
				fwaddr = walk_q[ADDR_W-1:0];
				if (walk_last) begin
					state_d = S_CNT_RD;
				end
			end
			S_CNT_RD: begin
				state_d = S_CNT_WR;
			end
			S_CNT_WR: begin
				cwe = 1'b1;
				if (chip_q && cidx_q != LAST_BLK) begin
					state_d = S_CNT_RD;
				end else begin
					state_d = S_RESP;
				end
			end
			S_WEAR_RD: begin
				state_d = S_WEAR_GET;
			end
			S_WEAR_GET: begin
				state_d = S_RESP;
			end
			S_RESP: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q   <= '0;
			cvalid_q <= '0;
		end else begin
			case (state_q)
				S_INIT, S_WALK: begin
					walk_q <= walk_q + (ADDR_W + 1)'(1);
				end
				S_DISPATCH: begin
					walk_q <= (cmd_t'(cmd_q) == CMD_CHIP_ERASE) ? '0
					                                            : (ADDR_W + 1)'(start_full);
				end
				S_CNT_WR: begin
					cvalid_q[cidx_q] <= 1'b1;
				end
				default: begin
				end
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				cmd_q   <= cmd;
				addr_q  <= address;
				wdata_q <= write_data;
			end
			S_DECODE: begin
				prod_q <= PROD_W'(addr_q) * PROD_W'(RECIP);
			end
			S_DISPATCH: begin
				rdata_q <= '0;
				wear_q  <= '0;
				if (cmd_t'(cmd_q) == CMD_CHIP_ERASE) begin
					chip_q     <= 1'b1;
					cidx_q     <= '0;
					walk_end_q <= CHIP_END;
				end else begin
					chip_q     <= 1'b0;
					cidx_q     <= CNT_AW'(blk_s);
					walk_end_q <= end_capped;
				end
			end
			S_RD_WAIT: begin
				rdata_q <= frdata;
			end
			S_CNT_WR: begin
				if (chip_q && cidx_q != LAST_BLK) begin
					cidx_q <= cidx_q + CNT_AW'(1);
				end
			end
			S_WEAR_GET: begin
				wear_q <= cur_count;
			end
			default: begin
			end
		endcase
	end

	assign busy       = (state_q != S_IDLE);
	assign done       = (state_q == S_RESP);
	assign read_data  = rdata_q;
	assign wear_count = wear_q;

endmodule

`default_nettype wire
